// ----- hw/rtl/bdm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and fixed field widths for the block dependence matrix.
// ----------------------------------------------------------------------------
package bdm_pkg;

	localparam int WRITE_FIELDS   = 2;
	localparam int READ_FIELDS    = 3;
	localparam int FIELD_REG_BITS = 16;
	localparam int MASK_BITS      = 32;
	localparam int SLOT_BITS      = 5;

	// one classified instruction, as it waits between front and back
	typedef struct packed {
		logic                                            real_branch;
		logic                                            is_barrier;
		logic                                            touches_memory;
		logic                                            is_store_op;
		logic [WRITE_FIELDS-1:0]                         write_valid;
		logic [WRITE_FIELDS-1:0][FIELD_REG_BITS-1:0]     write_reg;
		logic [READ_FIELDS-1:0]                          read_valid;
		logic [READ_FIELDS-1:0][FIELD_REG_BITS-1:0]      read_reg;
		logic                                            last_in_block;
	} desc_t;

	typedef struct packed {
		logic [MASK_BITS-1:0] pred_mask;
		logic [SLOT_BITS-1:0] slot_index;
		logic                 block_overflow;
	} result_t;

endpackage

// ----- hw/rtl/bdm_queue.sv -----
// ----------------------------------------------------------------------------
// bdm_queue
// Small register queue with push/full and pop/empty on either side.
// ----------------------------------------------------------------------------
module bdm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/bdm_front.sv -----
// ----------------------------------------------------------------------------
// bdm_front
// Accepts instruction beats, trims operands to the configured limits and
// queues the descriptor for the matrix back end.
// ----------------------------------------------------------------------------
module bdm_front #(
	parameter int MAX_WRITES = 2,
	parameter int MAX_READS  = 3,
	parameter int REG_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   real_branch,
	input  logic                   is_barrier,
	input  logic                   touches_memory,
	input  logic                   is_store_op,
	input  logic [1:0]             write_valid,
	input  logic [15:0]            write_reg_a,
	input  logic [15:0]            write_reg_b,
	input  logic [2:0]             read_valid,
	input  logic [15:0]            read_reg_a,
	input  logic [15:0]            read_reg_b,
	input  logic [15:0]            read_reg_c,
	input  logic                   last_in_block,
	output bdm_pkg::desc_t         desc,
	output logic                   desc_empty,
	input  logic                   desc_pop
);

	import bdm_pkg::*;

	desc_t                     desc_in;
	logic [FIELD_REG_BITS-1:0] reg_keep;
	logic [$bits(desc_t)-1:0]  desc_bits;

	always_comb begin
		reg_keep = '0;
		for (int b = 0; b < FIELD_REG_BITS; b++) begin
			reg_keep[b] = (b < REG_BITS);
		end
	end

	always_comb begin
		desc_in.real_branch    = real_branch;
		desc_in.is_barrier     = is_barrier;
		desc_in.touches_memory = touches_memory;
		desc_in.is_store_op    = is_store_op;
		desc_in.last_in_block  = last_in_block;
		desc_in.write_reg[0]   = write_reg_a & reg_keep;
		desc_in.write_reg[1]   = write_reg_b & reg_keep;
		desc_in.read_reg[0]    = read_reg_a & reg_keep;
		desc_in.read_reg[1]    = read_reg_b & reg_keep;
		desc_in.read_reg[2]    = read_reg_c & reg_keep;
		// operands past the configured limit never take part
		for (int i = 0; i < WRITE_FIELDS; i++) begin
			desc_in.write_valid[i] = write_valid[i] && (i < MAX_WRITES);
		end
		for (int k = 0; k < READ_FIELDS; k++) begin
			desc_in.read_valid[k] = read_valid[k] && (k < MAX_READS);
		end
	end

	bdm_queue #(
		.WIDTH($bits(desc_t)),
		.DEPTH(2)
	) u_desc_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (desc_in),
		.full  (full),
		.pop   (desc_pop),
		.rdata (desc_bits),
		.empty (desc_empty)
	);

	assign desc = desc_t'(desc_bits);

endmodule

// ----- hw/rtl/bdm_back.sv -----
// ----------------------------------------------------------------------------
// bdm_back
// Holds the entries of the current block, compares each queued descriptor
// against all of them at once and queues the predecessor mask.
// ----------------------------------------------------------------------------
module bdm_back #(
	parameter int MAX_BLOCK = 32,
	parameter int REG_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bdm_pkg::desc_t   desc,
	input  logic             desc_empty,
	output logic             desc_pop,
	output bdm_pkg::result_t res,
	output logic             res_empty,
	input  logic             res_pop
);

	import bdm_pkg::*;

	localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
	localparam int TBL      = (MAX_BLOCK < MASK_BITS) ? MAX_BLOCK : MASK_BITS;
	localparam int TW       = $clog2(TBL);
	localparam int CMP_BITS = (REG_BITS < FIELD_REG_BITS) ? REG_BITS : FIELD_REG_BITS;

	// entries past the mask width are counted but never compared, so not kept
	logic                                      e_branch_q  [TBL];
	logic                                      e_barrier_q [TBL];
	logic                                      e_memory_q  [TBL];
	logic                                      e_store_q   [TBL];
	logic [WRITE_FIELDS-1:0]                   e_wvalid_q  [TBL];
	logic [WRITE_FIELDS-1:0][CMP_BITS-1:0]     e_wreg_q    [TBL];
	logic [CNT_W-1:0]                          count_q;

	logic                       res_full;
	logic                       fire;
	logic                       overflow;
	logic                       store_en;
	logic [TW-1:0]              widx;
	logic [MASK_BITS-1:0]       mask;
	logic [CNT_W+SLOT_BITS-1:0] slot_ext;
	result_t                    res_in;
	logic [$bits(result_t)-1:0] res_bits;

	assign fire     = !desc_empty && !res_full;
	assign desc_pop = fire;
	assign overflow = (count_q == CNT_W'(MAX_BLOCK));
	assign store_en = fire && !overflow && (count_q < CNT_W'(TBL));
	assign widx     = count_q[TW-1:0];
	assign slot_ext = {{SLOT_BITS{1'b0}}, count_q};

	always_comb begin
		logic dep;
		mask = '0;
		for (int j = 0; j < TBL; j++) begin
			dep = e_branch_q[j] || desc.real_branch
				|| (e_barrier_q[j] && desc.touches_memory)
				|| (e_memory_q[j] && desc.is_store_op)
				|| (e_store_q[j] && desc.touches_memory);
			// read-after-write only
			for (int k = 0; k < READ_FIELDS; k++) begin
				for (int i = 0; i < WRITE_FIELDS; i++) begin
					if (desc.read_valid[k] && e_wvalid_q[j][i]
						&& (e_wreg_q[j][i] == desc.read_reg[k][CMP_BITS-1:0])) begin
						dep = 1'b1;
					end
				end
			end
			mask[j] = dep && (count_q > CNT_W'(j));
		end
	end

	always_comb begin
		res_in.pred_mask      = mask;
		res_in.slot_index     = overflow ? '0 : slot_ext[SLOT_BITS-1:0];
		res_in.block_overflow = overflow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			if (desc.last_in_block) begin
				count_q <= '0;
			end else if (!overflow) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			e_branch_q[widx]  <= desc.real_branch;
			e_barrier_q[widx] <= desc.is_barrier;
			e_memory_q[widx]  <= desc.touches_memory;
			e_store_q[widx]   <= desc.is_store_op;
			e_wvalid_q[widx]  <= desc.write_valid;
			for (int i = 0; i < WRITE_FIELDS; i++) begin
				e_wreg_q[widx][i] <= desc.write_reg[i][CMP_BITS-1:0];
			end
		end
	end

	bdm_queue #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.wdata (res_in),
		.full  (res_full),
		.pop   (res_pop),
		.rdata (res_bits),
		.empty (res_empty)
	);

	assign res = result_t'(res_bits);

endmodule

// ----- hw/rtl/block_dependence_matrix.sv -----
// ----------------------------------------------------------------------------
// block_dependence_matrix
// Per basic block dependence matrix: gives each instruction a mask of the
// earlier instructions of its block that it depends on.
// ----------------------------------------------------------------------------
// path: a push is registered in the front queue, then in the result queue (empty low)
// rate: one instruction per cycle while the result queue has room, the back end
//   comparing the new descriptor against every stored entry combinationally
// reset: queues empty and entry count cleared; stored entries are not
//   cleared, only entries below the count are ever compared
module block_dependence_matrix #(
	parameter int MAX_BLOCK  = 32,
	parameter int MAX_WRITES = 2,
	parameter int MAX_READS  = 3,
	parameter int REG_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        real_branch,
	input  logic        is_barrier,
	input  logic        touches_memory,
	input  logic        is_store_op,
	input  logic [1:0]  write_valid,
	input  logic [15:0] write_reg_a,
	input  logic [15:0] write_reg_b,
	input  logic [2:0]  read_valid,
	input  logic [15:0] read_reg_a,
	input  logic [15:0] read_reg_b,
	input  logic [15:0] read_reg_c,
	input  logic        last_in_block,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] pred_mask,
	output logic [4:0]  slot_index,
	output logic        block_overflow
);

	import bdm_pkg::*;

	desc_t   desc;
	logic    desc_empty;
	logic    desc_pop;
	result_t res;

	bdm_front #(
		.MAX_WRITES(MAX_WRITES),
		.MAX_READS (MAX_READS),
		.REG_BITS  (REG_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.real_branch   (real_branch),
		.is_barrier    (is_barrier),
		.touches_memory(touches_memory),
		.is_store_op   (is_store_op),
		.write_valid   (write_valid),
		.write_reg_a   (write_reg_a),
		.write_reg_b   (write_reg_b),
		.read_valid    (read_valid),
		.read_reg_a    (read_reg_a),
		.read_reg_b    (read_reg_b),
		.read_reg_c    (read_reg_c),
		.last_in_block (last_in_block),
		.desc          (desc),
		.desc_empty    (desc_empty),
		.desc_pop      (desc_pop)
	);

	bdm_back #(
		.MAX_BLOCK(MAX_BLOCK),
		.REG_BITS (REG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc      (desc),
		.desc_empty(desc_empty),
		.desc_pop  (desc_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign pred_mask      = res.pred_mask;
	assign slot_index     = res.slot_index;
	assign block_overflow = res.block_overflow;

endmodule
